FILE: src/afsk_tx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AFSK HDLC transmitter package
// Widths, codes, sine and phase-mapping tables, CRC-CCITT byte step.
// ----------------------------------------------------------------------------
package afsk_tx_pkg;

   localparam int PAYLOAD_DEPTH   = 64;
   localparam int MARK_TABLE_LEN  = 39;
   localparam int SPACE_TABLE_LEN = 21;

   localparam int MODE_W  = 2;
   localparam int ADDR_W  = 6;
   localparam int BYTE_W  = 8;
   localparam int LEVEL_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int LEN_W   = 7;
   localparam int FLAGS_W = 8;

   // input item modes
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BAUD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_START  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PAYLOAD_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEADING_FLAGS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRAILING_FLAGS  = 2'd2;

   localparam logic [LEN_W-1:0]   PAYLOAD_LENGTH_RST = 7'd57;
   localparam logic [FLAGS_W-1:0] LEADING_FLAGS_RST  = 8'd11;
   localparam logic [FLAGS_W-1:0] TRAILING_FLAGS_RST = 8'd3;

   // frame phases
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEADING  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CRC      = 3'd3;
   localparam logic [PHASE_W-1:0] PH_TRAILING = 3'd4;

   localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
   localparam logic [7:0]  IDLE_LEVEL = 8'd127;
   localparam logic [15:0] CRC_SEED   = 16'hFFFF;

   localparam int MARK_W  = 6;
   localparam int SPACE_W = 5;

   localparam logic [7:0] MARK_WAVE [MARK_TABLE_LEN] = '{
      8'd127, 8'd147, 8'd167, 8'd186, 8'd203, 8'd218, 8'd231, 8'd242, 8'd249,
      8'd253, 8'd254, 8'd252, 8'd246, 8'd237, 8'd226, 8'd212, 8'd195, 8'd177,
      8'd158, 8'd138, 8'd117, 8'd97,  8'd78,  8'd60,  8'd43,  8'd29,  8'd17,
      8'd9,   8'd3,   8'd0,   8'd1,   8'd5,   8'd12,  8'd22,  8'd35,  8'd50,
      8'd67,  8'd86,  8'd105};

   localparam logic [7:0] SPACE_WAVE [SPACE_TABLE_LEN] = '{
      8'd127, 8'd164, 8'd198, 8'd225, 8'd244, 8'd253, 8'd252, 8'd239, 8'd217,
      8'd186, 8'd151, 8'd114, 8'd78,  8'd46,  8'd21,  8'd5,   8'd0,   8'd6,
      8'd22,  8'd47,  8'd79};

   localparam logic [SPACE_W-1:0] TO_SPACE [MARK_TABLE_LEN] = '{
      5'd0,  5'd0,  5'd0,  5'd1,  5'd2,  5'd2,  5'd3,  5'd4,  5'd4,  5'd4,
      5'd5,  5'd6,  5'd6,  5'd7,  5'd7,  5'd8,  5'd8,  5'd9,  5'd9,  5'd10,
      5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd16,
      5'd16, 5'd17, 5'd17, 5'd18, 5'd18, 5'd19, 5'd19, 5'd20, 5'd20};

   localparam logic [MARK_W-1:0] TO_MARK [SPACE_TABLE_LEN] = '{
      6'd0,  6'd2,  6'd3,  6'd5,  6'd7,  6'd8,  6'd10, 6'd12, 6'd14, 6'd16,
      6'd18, 6'd20, 6'd22, 6'd24, 6'd26, 6'd27, 6'd29, 6'd31, 6'd33, 6'd34,
      6'd36};

   // one byte of reflected CRC-CCITT
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0] value);
      logic [7:0] d;
      d = value ^ crc[7:0];
      d = d ^ (d << 4);
      return {d, crc[15:8]} ^ {12'd0, d[7:4]} ^ ({8'd0, d} << 3);
   endfunction

endpackage
`default_nettype wire

FILE: src/afsk_tx_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AFSK transmitter request channel
// Ticks, payload loads and frame starts.
// ----------------------------------------------------------------------------
interface afsk_tx_req_if;
   logic                              valid;
   logic                              ready;
   logic [afsk_tx_pkg::MODE_W-1:0]    mode;
   logic [afsk_tx_pkg::ADDR_W-1:0]    payload_addr;
   logic [afsk_tx_pkg::BYTE_W-1:0]    payload_byte;

   modport source (output valid, mode, payload_addr, payload_byte, input ready);
   modport sink   (input valid, mode, payload_addr, payload_byte, output ready);
endinterface
`default_nettype wire

FILE: src/afsk_tx_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AFSK transmitter response channel
// DAC level and busy flag, one beat per request.
// ----------------------------------------------------------------------------
interface afsk_tx_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [afsk_tx_pkg::LEVEL_W-1:0]   dac_level;
   logic                              busy_res;

   modport source (output valid, dac_level, busy_res, input ready);
   modport sink   (input valid, dac_level, busy_res, output ready);
endinterface
`default_nettype wire

FILE: src/afsk_tx_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AFSK transmitter register write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface afsk_tx_csr_if;
   logic                                valid;
   logic                                ready;
   logic [afsk_tx_pkg::CSR_IDX_W-1:0]   index;
   logic [afsk_tx_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/afsk_hdlc_frame_transmitter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AFSK HDLC frame transmitter
// Sends one HDLC frame (flags, stuffed payload, CRC, flags) as NRZI two-tone
// phase-continuous audio, stepped by sample and baud tick beats.
// ----------------------------------------------------------------------------
// Use:
//   req_bus : one beat per event - sample tick, baud tick, payload byte load
//             or frame start. Loads and starts are dropped while busy.
//   rsp_bus : exactly one beat per request beat, in order: the DAC level and
//             the busy flag as they stand after that request.
//   csr_bus : register writes (payload length, leading / trailing flag
//             counts), always ready; write only while the block is idle.
// Timing:
//   Each response beat is registered in the output stage. One request is
//   taken every cycle while req ready is high; the per-beat work is a table
//   lookup plus bit logic, and the payload byte for the next baud tick is
//   prefetched from the payload RAM (registered read) as byte_cnt moves.
// Reset:
//   Registers take their defaults and the block comes up in the leading
//   flag phase, i.e. busy; the payload RAM is not cleared.
// Stall:
//   A two-deep output stage (register plus skid) takes a further request
//   while a response waits; req ready drops only once both are full.
// ----------------------------------------------------------------------------
module afsk_hdlc_frame_transmitter_top #(
   parameter int PAYLOAD_DEPTH = afsk_tx_pkg::PAYLOAD_DEPTH
) (
   input wire logic          clock,
   input wire logic          reset,
   afsk_tx_req_if.sink       req_bus,
   afsk_tx_rsp_if.source     rsp_bus,
   afsk_tx_csr_if.sink       csr_bus
);

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   // config registers
   logic [afsk_tx_pkg::LEN_W-1:0]   payload_length_ff;
   logic [afsk_tx_pkg::FLAGS_W-1:0] leading_flags_ff;
   logic [afsk_tx_pkg::FLAGS_W-1:0] trailing_flags_ff;

   // transmit state
   logic [afsk_tx_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [3:0]                       bit_pos_ff, bit_pos_in;
   logic [7:0]                       byte_cnt_ff, byte_cnt_in;
   logic [2:0]                       ones_ff, ones_in;
   logic [15:0]                      crc_ff, crc_in;
   logic                             tone_mark_ff, tone_mark_in;
   logic [afsk_tx_pkg::MARK_W-1:0]   mark_ph_ff, mark_ph_in;
   logic [afsk_tx_pkg::SPACE_W-1:0]  space_ph_ff, space_ph_in;
   logic [7:0]                       level_ff, level_in;

   // output stage
   logic       out_vld_ff, out_vld_in;
   logic [7:0] out_level_ff, out_level_in;
   logic       out_busy_ff, out_busy_in;
   logic       skid_vld_ff, skid_vld_in;
   logic [7:0] skid_level_ff;
   logic       skid_busy_ff;

   logic       req_acc, rsp_pop, skid_load;
   logic       ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0] cur_byte;

   // per-baud scratch
   logic       tx_bit, bit_active, stuffing, do_switch, consumed;
   logic [4:0] bit_pos_nx;
   logic [7:0] byte_cnt_nx;
   logic [8:0] eff_len;
   logic [6:0] mark_nx;
   logic [5:0] space_nx;

   assign req_bus.ready = !skid_vld_ff;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign rsp_pop       = out_vld_ff && rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   // ---- configuration --------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_length_ff <= afsk_tx_pkg::PAYLOAD_LENGTH_RST;
         leading_flags_ff  <= afsk_tx_pkg::LEADING_FLAGS_RST;
         trailing_flags_ff <= afsk_tx_pkg::TRAILING_FLAGS_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            afsk_tx_pkg::REG_PAYLOAD_LENGTH: begin
               payload_length_ff <= csr_bus.data[afsk_tx_pkg::LEN_W-1:0];
            end
            afsk_tx_pkg::REG_LEADING_FLAGS: begin
               leading_flags_ff <= csr_bus.data;
            end
            afsk_tx_pkg::REG_TRAILING_FLAGS: begin
               trailing_flags_ff <= csr_bus.data;
            end
            default: begin
            end
         endcase
      end
   end

   // length 0 acts as 1, anything beyond the store saturates
   always_comb begin
      if (payload_length_ff == '0) begin
         eff_len = 9'd1;
      end else if (9'(payload_length_ff) > 9'(PAYLOAD_DEPTH)) begin
         eff_len = 9'(PAYLOAD_DEPTH);
      end else begin
         eff_len = 9'(payload_length_ff);
      end
   end

   // ---- payload store --------------------------------------------------
   // Read address follows the next byte counter, so the byte for the
   // current counter is always sitting in the RAM output register.
   assign ram_we    = req_acc && (req_bus.mode == afsk_tx_pkg::MODE_LOAD) &&
                      (phase_ff == afsk_tx_pkg::PH_IDLE) &&
                      (9'(req_bus.payload_addr) < 9'(PAYLOAD_DEPTH));
   assign ram_waddr = AW'(req_bus.payload_addr);
   assign ram_raddr = AW'(byte_cnt_in);

   afsk_tx_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_payload_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (req_bus.payload_byte),
      .rd_addr    (ram_raddr),
      .rd_data_ff (cur_byte)
   );

   // ---- per-beat update ------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      bit_pos_in   = bit_pos_ff;
      byte_cnt_in  = byte_cnt_ff;
      ones_in      = ones_ff;
      crc_in       = crc_ff;
      tone_mark_in = tone_mark_ff;
      mark_ph_in   = mark_ph_ff;
      space_ph_in  = space_ph_ff;
      level_in     = level_ff;
      tx_bit       = 1'b0;
      bit_active   = 1'b0;
      stuffing     = 1'b0;
      do_switch    = 1'b0;
      consumed     = 1'b0;
      bit_pos_nx   = 5'(bit_pos_ff) + 5'd1;
      byte_cnt_nx  = byte_cnt_ff + 8'd1;
      mark_nx      = 7'(mark_ph_ff) + 7'd1;
      space_nx     = 6'(space_ph_ff) + 6'd1;

      if (req_acc) begin
         case (req_bus.mode)
            afsk_tx_pkg::MODE_SAMPLE: begin
               if (phase_ff == afsk_tx_pkg::PH_IDLE) begin
                  level_in = afsk_tx_pkg::IDLE_LEVEL;
               end else if (tone_mark_ff) begin
                  if (mark_nx >= 7'(afsk_tx_pkg::MARK_TABLE_LEN)) begin
                     mark_ph_in = '0;
                  end else begin
                     mark_ph_in = mark_nx[afsk_tx_pkg::MARK_W-1:0];
                  end
                  level_in = afsk_tx_pkg::MARK_WAVE[mark_ph_in];
               end else begin
                  if (space_nx >= 6'(afsk_tx_pkg::SPACE_TABLE_LEN)) begin
                     space_ph_in = '0;
                  end else begin
                     space_ph_in = space_nx[afsk_tx_pkg::SPACE_W-1:0];
                  end
                  level_in = afsk_tx_pkg::SPACE_WAVE[space_ph_in];
               end
            end

            afsk_tx_pkg::MODE_BAUD: begin
               case (phase_ff)
                  afsk_tx_pkg::PH_PAYLOAD: begin
                     tx_bit     = cur_byte[bit_pos_ff[2:0]];
                     bit_active = 1'b1;
                     stuffing   = 1'b1;
                  end
                  afsk_tx_pkg::PH_CRC: begin
                     tx_bit     = crc_ff[bit_pos_ff];
                     bit_active = 1'b1;
                     stuffing   = 1'b1;
                  end
                  afsk_tx_pkg::PH_LEADING, afsk_tx_pkg::PH_TRAILING: begin
                     tx_bit     = afsk_tx_pkg::FLAG_BYTE[bit_pos_ff[2:0]];
                     bit_active = 1'b1;
                  end
                  default: begin
                  end
               endcase

               // stuffing: a forced 0 after five 1s
               if (bit_active) begin
                  if (stuffing) begin
                     if (!tx_bit || ones_ff == 3'd5) begin
                        do_switch = 1'b1;
                        ones_in   = '0;
                     end else begin
                        ones_in = ones_ff + 3'd1;
                     end
                     consumed = (ones_in != 3'd5);
                  end else begin
                     do_switch = !tx_bit;
                     consumed  = 1'b1;
                  end
               end

               // NRZI: map phase into the other tone's table
               if (do_switch) begin
                  if (tone_mark_ff) begin
                     if (mark_ph_ff < afsk_tx_pkg::MARK_W'(afsk_tx_pkg::MARK_TABLE_LEN)) begin
                        space_ph_in = afsk_tx_pkg::TO_SPACE[mark_ph_ff];
                     end else begin
                        space_ph_in = '0;
                     end
                     tone_mark_in = 1'b0;
                  end else begin
                     if (space_ph_ff <
                         afsk_tx_pkg::SPACE_W'(afsk_tx_pkg::SPACE_TABLE_LEN)) begin
                        mark_ph_in = afsk_tx_pkg::TO_MARK[space_ph_ff];
                     end else begin
                        mark_ph_in = '0;
                     end
                     tone_mark_in = 1'b1;
                  end
               end

               if (consumed) begin
                  bit_pos_in = bit_pos_nx[3:0];
                  case (phase_ff)
                     afsk_tx_pkg::PH_PAYLOAD: begin
                        if (bit_pos_nx >= 5'd8) begin
                           bit_pos_in  = '0;
                           crc_in      = afsk_tx_pkg::crc_byte(crc_ff, cur_byte);
                           byte_cnt_in = byte_cnt_nx;
                           if (9'(byte_cnt_nx) >= eff_len) begin
                              byte_cnt_in = '0;
                              crc_in      = ~crc_in;
                              phase_in    = afsk_tx_pkg::PH_CRC;
                           end
                        end
                     end
                     afsk_tx_pkg::PH_CRC: begin
                        if (bit_pos_nx >= 5'd16) begin
                           bit_pos_in = '0;
                           phase_in   = afsk_tx_pkg::PH_TRAILING;
                        end
                     end
                     afsk_tx_pkg::PH_TRAILING: begin
                        if (bit_pos_nx >= 5'd8) begin
                           bit_pos_in  = '0;
                           byte_cnt_in = byte_cnt_nx;
                           // end of frame: next frame starts at table entry 0
                           if (byte_cnt_nx >= trailing_flags_ff) begin
                              byte_cnt_in = '0;
                              ones_in     = '0;
                              space_ph_in = afsk_tx_pkg::SPACE_W'(
                                               afsk_tx_pkg::SPACE_TABLE_LEN - 1);
                              mark_ph_in  = afsk_tx_pkg::MARK_W'(
                                               afsk_tx_pkg::MARK_TABLE_LEN - 1);
                              phase_in    = afsk_tx_pkg::PH_IDLE;
                           end
                        end
                     end
                     afsk_tx_pkg::PH_LEADING: begin
                        if (bit_pos_nx >= 5'd8) begin
                           bit_pos_in  = '0;
                           byte_cnt_in = byte_cnt_nx;
                           if (byte_cnt_nx >= leading_flags_ff) begin
                              byte_cnt_in = '0;
                              ones_in     = '0;
                              crc_in      = afsk_tx_pkg::CRC_SEED;
                              phase_in    = afsk_tx_pkg::PH_PAYLOAD;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end

            afsk_tx_pkg::MODE_START: begin
               if (phase_ff == afsk_tx_pkg::PH_IDLE) begin
                  phase_in = afsk_tx_pkg::PH_LEADING;
               end
            end

            default: begin
               // payload load handled by the RAM write port
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= afsk_tx_pkg::PH_LEADING;
         bit_pos_ff   <= '0;
         byte_cnt_ff  <= '0;
         ones_ff      <= '0;
         crc_ff       <= afsk_tx_pkg::CRC_SEED;
         tone_mark_ff <= 1'b0;
         mark_ph_ff   <= '0;
         space_ph_ff  <= '0;
         level_ff     <= afsk_tx_pkg::IDLE_LEVEL;
      end else begin
         phase_ff     <= phase_in;
         bit_pos_ff   <= bit_pos_in;
         byte_cnt_ff  <= byte_cnt_in;
         ones_ff      <= ones_in;
         crc_ff       <= crc_in;
         tone_mark_ff <= tone_mark_in;
         mark_ph_ff   <= mark_ph_in;
         space_ph_ff  <= space_ph_in;
         level_ff     <= level_in;
      end
   end

   // ---- output register and skid ---------------------------------------
   // New beat goes to the skid when the output register is full and stays.
   assign skid_load = req_acc && out_vld_ff && !rsp_pop;

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_level_in = out_level_ff;
      out_busy_in  = out_busy_ff;
      skid_vld_in  = skid_vld_ff;
      if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
      if (rsp_pop && skid_vld_ff) begin
         out_vld_in   = 1'b1;
         out_level_in = skid_level_ff;
         out_busy_in  = skid_busy_ff;
         skid_vld_in  = 1'b0;
      end else if (req_acc && !skid_load) begin
         out_vld_in   = 1'b1;
         out_level_in = level_in;
         out_busy_in  = (phase_in != afsk_tx_pkg::PH_IDLE);
      end
      if (skid_load) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_level_ff <= out_level_in;
      out_busy_ff  <= out_busy_in;
      if (skid_load) begin
         skid_level_ff <= level_in;
         skid_busy_ff  <= (phase_in != afsk_tx_pkg::PH_IDLE);
      end
   end

   assign rsp_bus.valid     = out_vld_ff;
   assign rsp_bus.dac_level = out_level_ff;
   assign rsp_bus.busy_res  = out_busy_ff;

endmodule
`default_nettype wire

FILE: src/afsk_tx_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module afsk_tx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: tb/sv/tb_afsk_hdlc_frame_transmitter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AFSK HDLC frame transmitter testbench
// Drives tick, load and start beats plus register writes, and predicts every
// response beat with its own model of the framing, stuffing, CRC, NRZI and
// tone tables. The first frame after reset runs on an unwritten payload RAM,
// so past its leading flags it is followed without checks and the model
// re-locks onto the tone that the block shows afterwards.
// ----------------------------------------------------------------------------
module tb_afsk_hdlc_frame_transmitter_top;
   import afsk_tx_pkg::*;

   localparam int     HALF_PERIOD  = 2;
   localparam int     RESET_CYCLES = 11;
   localparam int     STAGE_BEATS  = 560;       // random beats per idling stage
   localparam int     DRAIN_CYCLES = 4;         // margin after the drain wait
   localparam int     HOLD_CYCLES  = 300;       // long receiver hold-off
   localparam int     HOLD_AFTER   = 700;       // response beats before the hold-off
   localparam longint RUN_LIMIT    = 3_000_000;
   localparam logic [15:0]          CRC_POLY_REFLECTED = 16'h8408;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;   // no register behind it

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] value;
   } tx_req_t;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               busy;
      logic               unknown;   // not predictable, only observed
   } audio_beat_t;

   // -------------------------------------------------------------------------
   // Frame model and the queue of DAC beats it predicts
   // -------------------------------------------------------------------------
   class frame_scoreboard;
      logic [LEN_W-1:0]   len_reg;
      logic [FLAGS_W-1:0] lead_reg;
      logic [FLAGS_W-1:0] trail_reg;
      logic [PHASE_W-1:0] phase;
      logic [3:0]         bit_pos;
      logic [7:0]         byte_cnt;
      logic [2:0]         ones;
      logic [15:0]        crc;
      logic               tone_mark;
      logic [MARK_W-1:0]  mark_ph;
      logic [SPACE_W-1:0] space_ph;
      logic [7:0]         level;
      logic [7:0]         store [PAYLOAD_DEPTH];
      bit                 blind;
      audio_beat_t        expected_audio [$];
      logic [7:0]         seen_level;
      logic               seen_busy;
      int                 errors, beats_checked, frames_sent, bytes_sent, stuffed_bits;

      function new();
         len_reg   = PAYLOAD_LENGTH_RST;
         lead_reg  = LEADING_FLAGS_RST;
         trail_reg = TRAILING_FLAGS_RST;
         phase     = PH_LEADING;
         bit_pos   = '0;
         byte_cnt  = '0;
         ones      = '0;
         crc       = CRC_SEED;
         tone_mark = 1'b0;
         mark_ph   = '0;
         space_ph  = '0;
         level     = IDLE_LEVEL;
         foreach (store[i]) store[i] = '0;
         blind = 1'b0;
         errors = 0;
         beats_checked = 0;
         frames_sent = 0;
         bytes_sent = 0;
         stuffed_bits = 0;
      endfunction

      task flag_mismatch(input string what);
         errors++;
         $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      function void set_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_PAYLOAD_LENGTH: len_reg   = data[LEN_W-1:0];
            REG_LEADING_FLAGS:  lead_reg  = data;
            REG_TRAILING_FLAGS: trail_reg = data;
            default: ;
         endcase
      endfunction

      // bitwise reflected CRC-CCITT over one byte, LSB first
      function logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] value);
         logic [15:0] c;
         c = c_in;
         for (int i = 0; i < 8; i++)
            c = (c[0] ^ value[i]) ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
         return c;
      endfunction

      function int frame_length();
         int n;
         n = len_reg;
         if (n == 0) n = 1;
         if (n > PAYLOAD_DEPTH) n = PAYLOAD_DEPTH;
         return n;
      endfunction

      // NRZI: carry the table position across into the other tone
      function void swap_tone();
         if (tone_mark) begin
            space_ph  = (mark_ph < MARK_TABLE_LEN) ? TO_SPACE[mark_ph] : '0;
            tone_mark = 1'b0;
         end else begin
            mark_ph   = (space_ph < SPACE_TABLE_LEN) ? TO_MARK[space_ph] : '0;
            tone_mark = 1'b1;
         end
      endfunction

      // one line bit with stuffing; 1 when the data bit has been used up
      function bit stuff_bit(input logic b);
         if (!b || ones == 3'd5) begin
            if (ones == 3'd5) stuffed_bits++;
            swap_tone();
            ones = '0;
         end else begin
            ones++;
         end
         return ones != 3'd5;
      endfunction

      function void baud_step();
         logic [7:0] cur;
         case (phase)
            PH_PAYLOAD: begin
               cur = (byte_cnt < PAYLOAD_DEPTH) ? store[byte_cnt[ADDR_W-1:0]] : '0;
               if (stuff_bit(cur[bit_pos[2:0]])) begin
                  if (bit_pos == 4'd7) begin
                     bit_pos = '0;
                     crc = crc_step(crc, cur);
                     byte_cnt++;
                     bytes_sent++;
                     if (byte_cnt >= frame_length()) begin
                        byte_cnt = '0;
                        crc      = ~crc;
                        phase    = PH_CRC;
                     end
                  end else begin
                     bit_pos++;
                  end
               end
            end
            PH_CRC: begin
               if (stuff_bit(crc[bit_pos])) begin
                  if (bit_pos == 4'd15) begin
                     bit_pos = '0;
                     phase   = PH_TRAILING;
                  end else begin
                     bit_pos++;
                  end
               end
            end
            PH_LEADING, PH_TRAILING: begin
               if (!FLAG_BYTE[bit_pos[2:0]]) swap_tone();
               if (bit_pos == 4'd7) begin
                  bit_pos = '0;
                  byte_cnt++;
                  if (phase == PH_TRAILING) begin
                     if (byte_cnt >= trail_reg) begin
                        byte_cnt = '0;
                        ones     = '0;
                        space_ph = SPACE_TABLE_LEN - 1;
                        mark_ph  = MARK_TABLE_LEN - 1;
                        phase    = PH_IDLE;
                        frames_sent++;
                     end
                  end else if (byte_cnt >= lead_reg) begin
                     byte_cnt = '0;
                     ones     = '0;
                     crc      = CRC_SEED;
                     phase    = PH_PAYLOAD;
                  end
               end else begin
                  bit_pos++;
               end
            end
            default: ;
         endcase
      endfunction

      function void sample_step();
         if (phase == PH_IDLE) begin
            level = IDLE_LEVEL;
         end else if (tone_mark) begin
            mark_ph = mark_ph + 1'b1;
            if (mark_ph >= MARK_TABLE_LEN) mark_ph = '0;
            level = MARK_WAVE[mark_ph];
         end else begin
            space_ph = space_ph + 1'b1;
            if (space_ph >= SPACE_TABLE_LEN) space_ph = '0;
            level = SPACE_WAVE[space_ph];
         end
      endfunction

      function void note_request(input tx_req_t r);
         audio_beat_t e;
         case (r.mode)
            MODE_SAMPLE: sample_step();
            MODE_BAUD:   baud_step();
            MODE_LOAD:   if (phase == PH_IDLE) store[r.addr] = r.value;
            MODE_START:  if (phase == PH_IDLE) phase = PH_LEADING;
            default: ;
         endcase
         e.level   = level;
         e.busy    = (phase != PH_IDLE);
         e.unknown = blind;
         expected_audio.push_back(e);
      endfunction

      task check_response(input logic [7:0] lvl, input logic busy);
         audio_beat_t e;
         seen_level = lvl;
         seen_busy  = busy;
         if (expected_audio.size() == 0) begin
            flag_mismatch($sformatf("response beat with nothing expected (level %0d busy %b)",
                                    lvl, busy));
            return;
         end
         e = expected_audio.pop_front();
         if (e.unknown) return;
         beats_checked++;
         if (lvl !== e.level)
            flag_mismatch($sformatf("dac_level %0d, expected %0d", lvl, e.level));
         if (busy !== e.busy)
            flag_mismatch($sformatf("busy_res %b, expected %b", busy, e.busy));
      endtask

      // end of the unchecked frame: everything but the tone is known again
      function void resume_idle();
         phase    = PH_IDLE;
         bit_pos  = '0;
         byte_cnt = '0;
         ones     = '0;
         mark_ph  = MARK_TABLE_LEN - 1;
         space_ph = SPACE_TABLE_LEN - 1;
         level    = seen_level;
         blind    = 1'b0;
      endfunction

      // after start and two sample ticks the second table entry tells the tone
      task resolve_tone();
         if (seen_level === MARK_WAVE[1]) begin
            tone_mark = 1'b1;
            mark_ph   = 1;
            space_ph  = SPACE_TABLE_LEN - 1;
         end else if (seen_level === SPACE_WAVE[1]) begin
            tone_mark = 1'b0;
            space_ph  = 1;
            mark_ph   = MARK_TABLE_LEN - 1;
         end else begin
            flag_mismatch($sformatf("level %0d after tone probe is neither tone", seen_level));
         end
         phase    = PH_LEADING;
         bit_pos  = '0;
         byte_cnt = '0;
         ones     = '0;
         level    = seen_level;
         blind    = 1'b0;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block and channels
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   afsk_tx_req_if req_bus ();
   afsk_tx_rsp_if rsp_bus ();
   afsk_tx_csr_if csr_bus ();

   afsk_hdlc_frame_transmitter_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frame_scoreboard sb;
   int  send_gap_pct;     // chance in 100 that the sender idles a cycle
   int  recv_gap_pct;     // chance in 100 that the receiver stalls a cycle
   int  beats_sent;
   int  rsp_seen;
   int  hold_left;
   int  holds_done;
   int  input_stalls;
   bit  offering;         // req valid as last driven

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #RUN_LIMIT;
      $display("** afsk_hdlc_frame_transmitter_top: FAILED **");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: checks each response beat, throttles ready, and once holds off
   // for a long stretch while the sender is offering, so the output stage
   // fills and req stalls
   // -------------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && req_bus.valid && !req_bus.ready) input_stalls++;
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response(rsp_bus.dac_level, rsp_bus.busy_res);
            rsp_seen++;
         end
         if (holds_done == 0 && rsp_seen >= HOLD_AFTER && offering) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------
   task automatic drop_valid();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // one request beat; valid stays up afterwards unless the next call idles
   task automatic send_beat(input tx_req_t r);
      while ($urandom_range(99) < send_gap_pct) begin
         drop_valid();
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= r.mode;
      req_bus.payload_addr <= r.addr;
      req_bus.payload_byte <= r.value;
      offering = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(r);
      beats_sent++;
   endtask

   // sender pauses until every predicted beat has come back
   task automatic wait_drained();
      drop_valid();
      while (sb.expected_audio.size() != 0) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx,
                           input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.set_register(idx, data);
   endtask

   // all three registers back to back, optionally a write to the spare index
   task automatic write_config(input logic [7:0] len, input logic [7:0] lead,
                               input logic [7:0] trail, input bit spare);
      csr_beat(REG_PAYLOAD_LENGTH, len);
      csr_beat(REG_LEADING_FLAGS, lead);
      csr_beat(REG_TRAILING_FLAGS, trail);
      if (spare) csr_beat(REG_SPARE, CSR_DATA_W'($urandom_range(255)));
      csr_bus.valid <= 1'b0;
   endtask

   // bytes biased to all-ones (stuffing), zeros and flag patterns
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(4))
         0:       return 8'hFF;
         1:       return 8'h00;
         2:       return FLAG_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic tx_req_t make_req(input logic [MODE_W-1:0] mode);
      tx_req_t r;
      r.mode  = mode;
      r.addr  = ADDR_W'($urandom_range(PAYLOAD_DEPTH - 1));
      r.value = pick_byte();
      return r;
   endfunction

   function automatic logic [7:0] pick_length();
      case ($urandom_range(39))
         0, 1:    return 8'd0;    // acts as one byte
         2:       return 8'hFF;   // 127 after masking, saturates at full depth
         default: return 8'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [7:0] pick_flags();
      if ($urandom_range(9) == 0) return 8'd0;   // acts as one flag
      return 8'($urandom_range(1, 3));
   endfunction

   // drive a frame to its end: mostly baud ticks, some sample ticks, and a
   // little noise of loads and starts that a busy block must drop
   task automatic run_frame(input bit with_start, input int noise_pct, input int sample_pct);
      int k;
      if (with_start) send_beat(make_req(MODE_START));
      while (sb.phase != PH_IDLE) begin
         k = $urandom_range(99);
         if (k < noise_pct)
            send_beat(make_req($urandom_range(1) ? MODE_LOAD : MODE_START));
         else if (k < noise_pct + sample_pct)
            send_beat(make_req(MODE_SAMPLE));
         else
            send_beat(make_req(MODE_BAUD));
      end
   endtask

   // one idle gap with optional register change and payload rewrites, then a frame
   task automatic random_episode();
      int n;
      int k;
      wait_drained();
      if ($urandom_range(3) != 0)
         write_config(pick_length(), pick_flags(), pick_flags(), $urandom_range(9) == 0);
      n = $urandom_range(6);
      repeat (n) begin
         k = $urandom_range(9);
         if (k < 6)      send_beat(make_req(MODE_LOAD));
         else if (k < 8) send_beat(make_req(MODE_SAMPLE));
         else            send_beat(make_req(MODE_BAUD));
      end
      run_frame(1'b1, 5, 25);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int stage_end;
      sb = new();
      beats_sent   = 0;
      rsp_seen     = 0;
      hold_left    = 0;
      holds_done   = 0;
      input_stalls = 0;
      offering     = 1'b0;
      send_gap_pct = 19;
      recv_gap_pct = 81;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.mode         <= MODE_SAMPLE;
      req_bus.payload_addr <= '0;
      req_bus.payload_byte <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= REG_PAYLOAD_LENGTH;
      csr_bus.data         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The block leaves reset busy in the leading flags. One flag and one
      // payload byte keep the unknown stretch short.
      write_config(8'd1, 8'd1, 8'd1, 1'b0);
      send_beat(make_req(MODE_SAMPLE));
      send_beat(tx_req_t'{MODE_LOAD, ADDR_W'(PAYLOAD_DEPTH - 1), 8'hFF});  // dropped: busy
      send_beat(make_req(MODE_START));                                    // dropped: busy
      while (sb.phase == PH_LEADING) begin
         send_beat(make_req(MODE_BAUD));
         if ($urandom_range(1)) send_beat(make_req(MODE_SAMPLE));
      end

      // payload RAM unwritten: follow the rest of the frame beat by beat,
      // unchecked, until the block reports idle
      sb.blind = 1'b1;
      do begin
         send_beat(make_req(MODE_BAUD));
         wait_drained();
      end while (sb.seen_busy !== 1'b0);
      sb.resume_idle();

      // idle ticks, then fill the whole store, extremes at both ends
      send_beat(make_req(MODE_BAUD));
      send_beat(make_req(MODE_SAMPLE));
      for (int a = 0; a < PAYLOAD_DEPTH; a++) begin
         if (a == 0)                      send_beat(tx_req_t'{MODE_LOAD, ADDR_W'(a), 8'hFF});
         else if (a == PAYLOAD_DEPTH - 1) send_beat(tx_req_t'{MODE_LOAD, ADDR_W'(a), 8'h00});
         else                             send_beat(tx_req_t'{MODE_LOAD, ADDR_W'(a), pick_byte()});
      end

      // zero length and zero flag counts, plus the index with no register
      wait_drained();
      write_config(8'd0, 8'd0, 8'd0, 1'b1);

      // tone left by the unchecked frame: start plus two sample ticks shows it
      sb.blind = 1'b1;
      send_beat(make_req(MODE_START));
      send_beat(make_req(MODE_SAMPLE));
      send_beat(make_req(MODE_SAMPLE));
      wait_drained();
      sb.resolve_tone();
      run_frame(1'b0, 5, 30);

      // three idling stages; the last also carries the full-size frame
      for (int stage = 0; stage < 3; stage++) begin
         stage_end = beats_sent + STAGE_BEATS;
         case (stage)
            0: begin
               send_gap_pct = 19;
               recv_gap_pct = 81;
            end
            1: begin
               send_gap_pct = 81;
               recv_gap_pct = 19;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
               wait_drained();
               write_config(8'd64, 8'd2, 8'd2, 1'b0);
               run_frame(1'b1, 2, 10);
            end
         endcase
         while (beats_sent < stage_end) random_episode();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_audio.size() != 0)
         sb.flag_mismatch($sformatf("%0d response beats never arrived",
                                    sb.expected_audio.size()));

      $display("Run: %0d beats, %0d checked, %0d frames, %0d bytes, %0d stuffed bits",
               beats_sent, sb.beats_checked, sb.frames_sent, sb.bytes_sent, sb.stuffed_bits);
      $display("Back-pressure: %0d hold-offs, req stalled on %0d cycles, %0d mismatches",
               holds_done, input_stalls, sb.errors);
      if (sb.errors == 0) begin
         $display("** afsk_hdlc_frame_transmitter_top: PASSED **");
      end else begin
         $display("** afsk_hdlc_frame_transmitter_top: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
src/afsk_tx_pkg.sv
src/afsk_tx_req_if.sv
src/afsk_tx_rsp_if.sv
src/afsk_tx_csr_if.sv
src/afsk_tx_ram.sv
src/afsk_hdlc_frame_transmitter_top.sv
tb/sv/tb_afsk_hdlc_frame_transmitter_top.sv
